// ===== rtl/core/csim_pkg.sv =====
package csim_pkg;

    // element and accumulator sizes
    localparam int ELEM_W        = 16;
    localparam int LOG_MAX_PAIRS = 16;
    localparam int CNT_W         = LOG_MAX_PAIRS + 1;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int SUM_W         = 48;

    // norm product is built from ELEM_W digits of each norm sum
    localparam int NDIG      = (SUM_W + ELEM_W - 1) / ELEM_W;
    localparam int DIG_IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int SH_W      = $clog2(2 * NDIG);
    localparam int PAD_W     = NDIG * ELEM_W;
    localparam int BIG_W     = 2 * PAD_W;

    // square root and quotient
    localparam int ROOT_W    = PAD_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQ_CNT_W  = $clog2(ROOT_W);
    localparam int SIM_W     = 16;
    localparam int DIV_CNT_W = $clog2(SIM_W);

    // result fields
    localparam int STAT_W     = 2;
    localparam int CNT_OUT_W  = 17;
    localparam logic [CNT_OUT_W-1:0] COUNT_MAX = '1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_LONG = 2'd2;

endpackage

// ===== rtl/core/csim_mul.sv =====
module csim_mul (
    input  logic                        i_clk,
    input  logic [csim_pkg::ELEM_W-1:0] i_x,
    input  logic [csim_pkg::ELEM_W-1:0] i_y,
    output logic [csim_pkg::PROD_W-1:0] o_p
);

    logic [csim_pkg::PROD_W-1:0] r_p;

    // shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_p <= csim_pkg::PROD_W'(i_x) * csim_pkg::PROD_W'(i_y);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/csim_sqrt.sv =====
module csim_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [csim_pkg::BIG_W-1:0]  i_rad,
    output logic                        o_done,
    output logic [csim_pkg::ROOT_W-1:0] o_root
);

    localparam logic [csim_pkg::SQ_CNT_W-1:0] SQ_LAST =
        csim_pkg::SQ_CNT_W'(csim_pkg::ROOT_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [csim_pkg::SQ_CNT_W-1:0] r_cnt;
    logic [csim_pkg::BIG_W-1:0]    r_rad;
    logic [csim_pkg::REM_W-1:0]    r_rem;
    logic [csim_pkg::ROOT_W-1:0]   r_root;

    logic [csim_pkg::REM_W-1:0] rem_sh;
    logic [csim_pkg::REM_W-1:0] trial;
    logic                       fits;

    // one root bit per step: bring down two radicand bits, trial subtract
    assign rem_sh = {r_rem[csim_pkg::REM_W-3:0], r_rad[csim_pkg::BIG_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == SQ_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[csim_pkg::ROOT_W-2:0], fits};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/core/csim_div.sv =====
module csim_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [csim_pkg::SUM_W-1:0]  i_num,
    input  logic [csim_pkg::ROOT_W-1:0] i_den,
    output logic                        o_done,
    output logic [csim_pkg::SIM_W-1:0]  o_quo
);

    localparam logic [csim_pkg::DIV_CNT_W-1:0] DIV_LAST =
        csim_pkg::DIV_CNT_W'(csim_pkg::SIM_W - 1);

    logic                           r_busy;
    logic                           r_done;
    logic [csim_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [csim_pkg::ROOT_W-1:0]    r_rem;
    logic [csim_pkg::ROOT_W-1:0]    r_den;
    logic [csim_pkg::SIM_W-1:0]     r_quo;

    logic [csim_pkg::ROOT_W-1:0] num_ext;
    logic                        sat;
    logic [csim_pkg::ROOT_W:0]   rem_sh;
    logic [csim_pkg::ROOT_W:0]   diff;
    logic                        fits;

    // quotient of num * 2^16 saturates exactly when num >= den
    assign num_ext = csim_pkg::ROOT_W'(i_num);
    assign sat     = (num_ext >= i_den);

    // restoring division, one quotient bit per step
    assign rem_sh = {r_rem, 1'b0};
    assign diff   = rem_sh - {1'b0, r_den};
    assign fits   = (rem_sh >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !sat;
                r_done <= sat;
            end else if (r_busy && r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num_ext;
            r_den <= i_den;
            r_cnt <= '0;
            r_quo <= sat ? '1 : '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[csim_pkg::ROOT_W-1:0] : rem_sh[csim_pkg::ROOT_W-1:0];
            r_quo <= {r_quo[csim_pkg::SIM_W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/cosine_similarity_stream.sv =====
// cosine similarity of two streamed unsigned vectors
// input channel: i_valid / o_stall with i_elem_a, i_elem_b, i_last_pair; one element
//   pair per request, a request is taken when i_valid is high and o_stall is low
// output channel: o_valid / i_stall with o_similarity (unsigned Q0.16, 1.0 shows as
//   65535), o_status (0 ok, 1 zero norm, 2 too many pairs) and o_pair_count
// each pair goes through one shared 16x16 multiplier three times, so a pair that
//   is not last holds o_stall in S_DOT, S_SQA, S_SQB and S_ACC, until back in S_IDLE
// a last pair also runs the norm product (9 multiplier passes), a 48-step square
//   root and a 16-step divide before its result shows; a saturating quotient
//   skips the divide steps, and a zero norm skips all three
// pairs beyond 65536 per vector are dropped and flag status 2
// reset clears the sums, the pair count and the output valid flag; no result pending
// while the receiver stalls, the result holds in the output register and the
//   block keeps taking pairs; a later last pair waits until that result is taken
module cosine_similarity_stream (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [15:0]                    i_elem_a,
    input  logic [15:0]                    i_elem_b,
    input  logic                           i_last_pair,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [csim_pkg::SIM_W-1:0]     o_similarity,
    output logic [csim_pkg::STAT_W-1:0]    o_status,
    output logic [csim_pkg::CNT_OUT_W-1:0] o_pair_count
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOT,
        S_SQA,
        S_SQB,
        S_ACC,
        S_CHECK,
        S_PROD,
        S_PDRAIN,
        S_RSTART,
        S_ROOT,
        S_DIV,
        S_DONE
    } t_state;

    localparam int DIG_LAST_W = csim_pkg::DIG_IDX_W;
    localparam logic [DIG_LAST_W-1:0] DIG_LAST = DIG_LAST_W'(csim_pkg::NDIG - 1);

    t_state                          r_state, n_state;
    logic [csim_pkg::ELEM_W-1:0]     r_a, n_a;
    logic [csim_pkg::ELEM_W-1:0]     r_b, n_b;
    logic                            r_last, n_last;
    logic [csim_pkg::SUM_W-1:0]      r_dot, n_dot;
    logic [csim_pkg::SUM_W-1:0]      r_na, n_na;
    logic [csim_pkg::SUM_W-1:0]      r_nb, n_nb;
    logic [csim_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            r_long, n_long;
    logic [csim_pkg::BIG_W-1:0]      r_big, n_big;
    logic [csim_pkg::DIG_IDX_W-1:0]  r_di, n_di;
    logic [csim_pkg::DIG_IDX_W-1:0]  r_dj, n_dj;
    logic                            r_pv, n_pv;
    logic [csim_pkg::SH_W-1:0]       r_psh, n_psh;
    logic [csim_pkg::SIM_W-1:0]      r_sim, n_sim;
    logic [csim_pkg::STAT_W-1:0]     r_stat, n_stat;
    logic                            r_out_valid, n_out_valid;
    logic [csim_pkg::SIM_W-1:0]      r_out_sim, n_out_sim;
    logic [csim_pkg::STAT_W-1:0]     r_out_stat, n_out_stat;
    logic [csim_pkg::CNT_OUT_W-1:0]  r_out_cnt, n_out_cnt;

    logic [csim_pkg::ELEM_W-1:0]     mul_x;
    logic [csim_pkg::ELEM_W-1:0]     mul_y;
    logic [csim_pkg::PROD_W-1:0]     mul_p;
    logic [csim_pkg::PAD_W-1:0]      na_pad;
    logic [csim_pkg::PAD_W-1:0]      nb_pad;
    logic [csim_pkg::BIG_W-1:0]      part_shifted;
    logic                            sqrt_start;
    logic                            sqrt_done;
    logic [csim_pkg::ROOT_W-1:0]     sqrt_root;
    logic                            div_start;
    logic                            div_done;
    logic [csim_pkg::SIM_W-1:0]      div_quo;
    logic                            in_take;
    logic                            out_free;

    // saturating add of a product into a running sum
    function automatic logic [csim_pkg::SUM_W-1:0] sat_add(
        input logic [csim_pkg::SUM_W-1:0]  sum,
        input logic [csim_pkg::PROD_W-1:0] prod
    );
        logic [csim_pkg::SUM_W:0] s;
        s = {1'b0, sum} + (csim_pkg::SUM_W + 1)'(prod);
        return s[csim_pkg::SUM_W] ? '1 : s[csim_pkg::SUM_W-1:0];
    endfunction

    // shared units
    csim_mul u_mul (
        .i_clk (i_clk),
        .i_x   (mul_x),
        .i_y   (mul_y),
        .o_p   (mul_p)
    );

    csim_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_big),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    csim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_dot),
        .i_den   (sqrt_root),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // handshakes
    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // digits of the norm sums for the wide product
    assign na_pad       = csim_pkg::PAD_W'(r_na);
    assign nb_pad       = csim_pkg::PAD_W'(r_nb);
    assign part_shifted = csim_pkg::BIG_W'(mul_p) << (int'(r_psh) * csim_pkg::ELEM_W);

    // multiplier operand select
    always_comb begin
        case (r_state)
            S_SQA: begin
                mul_x = r_a;
                mul_y = r_a;
            end
            S_SQB: begin
                mul_x = r_b;
                mul_y = r_b;
            end
            S_PROD: begin
                mul_x = na_pad[r_di * csim_pkg::ELEM_W +: csim_pkg::ELEM_W];
                mul_y = nb_pad[r_dj * csim_pkg::ELEM_W +: csim_pkg::ELEM_W];
            end
            default: begin
                mul_x = r_a;
                mul_y = r_b;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_last      = r_last;
        n_dot       = r_dot;
        n_na        = r_na;
        n_nb        = r_nb;
        n_cnt       = r_cnt;
        n_long      = r_long;
        n_big       = r_big;
        n_di        = r_di;
        n_dj        = r_dj;
        n_pv        = r_pv;
        n_psh       = r_psh;
        n_sim       = r_sim;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && i_stall;
        n_out_sim   = r_out_sim;
        n_out_stat  = r_out_stat;
        n_out_cnt   = r_out_cnt;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_a    = csim_pkg::ELEM_W'(i_elem_a);
                    n_b    = csim_pkg::ELEM_W'(i_elem_b);
                    n_last = i_last_pair;
                    if (r_cnt[csim_pkg::LOG_MAX_PAIRS]) begin
                        // vector full: drop the pair
                        n_long  = 1'b1;
                        n_state = i_last_pair ? S_CHECK : S_IDLE;
                    end else begin
                        n_state = S_DOT;
                    end
                end
            end
            S_DOT: begin
                n_state = S_SQA;
            end
            S_SQA: begin
                n_dot   = sat_add(r_dot, mul_p);
                n_state = S_SQB;
            end
            S_SQB: begin
                n_na    = sat_add(r_na, mul_p);
                n_state = S_ACC;
            end
            S_ACC: begin
                n_nb    = sat_add(r_nb, mul_p);
                n_cnt   = r_cnt + 1'b1;
                n_state = r_last ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                if (r_na == '0 || r_nb == '0) begin
                    n_sim   = '0;
                    n_stat  = r_long ? csim_pkg::ST_LONG : csim_pkg::ST_ZERO;
                    n_state = S_DONE;
                end else begin
                    n_big   = '0;
                    n_di    = '0;
                    n_dj    = '0;
                    n_pv    = 1'b0;
                    n_state = S_PROD;
                end
            end
            S_PROD: begin
                // issue one digit product, add the one issued before
                if (r_pv) begin
                    n_big = r_big + part_shifted;
                end
                n_pv  = 1'b1;
                n_psh = csim_pkg::SH_W'(r_di) + csim_pkg::SH_W'(r_dj);
                if (r_dj == DIG_LAST) begin
                    n_dj = '0;
                    if (r_di == DIG_LAST) begin
                        n_state = S_PDRAIN;
                    end else begin
                        n_di = r_di + 1'b1;
                    end
                end else begin
                    n_dj = r_dj + 1'b1;
                end
            end
            S_PDRAIN: begin
                n_big   = r_big + part_shifted;
                n_state = S_RSTART;
            end
            S_RSTART: begin
                sqrt_start = 1'b1;
                n_state    = S_ROOT;
            end
            S_ROOT: begin
                if (sqrt_done) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_sim   = div_quo;
                    n_stat  = r_long ? csim_pkg::ST_LONG : csim_pkg::ST_OK;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand the result over and clear for the next vector
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sim   = r_sim;
                    n_out_stat  = r_stat;
                    if (csim_pkg::CNT_W > csim_pkg::CNT_OUT_W
                            && r_cnt > csim_pkg::CNT_W'(csim_pkg::COUNT_MAX)) begin
                        n_out_cnt = csim_pkg::COUNT_MAX;
                    end else begin
                        n_out_cnt = csim_pkg::CNT_OUT_W'(r_cnt);
                    end
                    n_dot   = '0;
                    n_na    = '0;
                    n_nb    = '0;
                    n_cnt   = '0;
                    n_long  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dot       <= '0;
            r_na        <= '0;
            r_nb        <= '0;
            r_cnt       <= '0;
            r_long      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dot       <= n_dot;
            r_na        <= n_na;
            r_nb        <= n_nb;
            r_cnt       <= n_cnt;
            r_long      <= n_long;
            r_out_valid <= n_out_valid;
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_last     <= n_last;
        r_big      <= n_big;
        r_di       <= n_di;
        r_dj       <= n_dj;
        r_pv       <= n_pv;
        r_psh      <= n_psh;
        r_sim      <= n_sim;
        r_stat     <= n_stat;
        r_out_sim  <= n_out_sim;
        r_out_stat <= n_out_stat;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_valid      = r_out_valid;
    assign o_similarity = r_out_sim;
    assign o_status     = r_out_stat;
    assign o_pair_count = r_out_cnt;

endmodule

// ===== rtl/core/csim_checker.sv =====
module csim_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [csim_pkg::SIM_W-1:0]     o_similarity,
    input logic [csim_pkg::STAT_W-1:0]    o_status,
    input logic [csim_pkg::CNT_OUT_W-1:0] o_pair_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_similarity)
            && $stable(o_status) && $stable(o_pair_count))
        else $error("stalled result changed");

    // a result never appears right after a request is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result appeared one cycle after a request");

    // zero norm gives zero similarity
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == csim_pkg::ST_ZERO |-> o_similarity == '0)
        else $error("zero norm with nonzero similarity");

    // a good result covers at least one pair
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == csim_pkg::ST_OK |-> o_pair_count != '0)
        else $error("ok result with no pairs");

endmodule

bind cosine_similarity_stream csim_checker u_csim_checker (.*);

// ===== tb/tb_cosine_similarity_stream.sv =====
module tb_cosine_similarity_stream;

    localparam int PAIR_LIMIT     = 1 << csim_pkg::LOG_MAX_PAIRS;
    localparam int RANDOM_PAIRS   = 1750;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 200;
    localparam logic [csim_pkg::SUM_W-1:0] SUM_SAT = '1;

    typedef struct {
        logic [csim_pkg::SIM_W-1:0]     sim;
        logic [csim_pkg::STAT_W-1:0]    status;
        logic [csim_pkg::CNT_OUT_W-1:0] count;
    } t_sim_result;

    typedef enum {
        VEC_FULL, VEC_SMALL, VEC_SPARSE, VEC_HIGH, VEC_ALIKE, VEC_ZERO_A
    } t_vec_style;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [15:0]                    i_elem_a = '0;
    logic [15:0]                    i_elem_b = '0;
    logic                           i_last_pair = 1'b0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [csim_pkg::SIM_W-1:0]     o_similarity;
    logic [csim_pkg::STAT_W-1:0]    o_status;
    logic [csim_pkg::CNT_OUT_W-1:0] o_pair_count;

    // predictor state
    logic [csim_pkg::SUM_W-1:0] dot_acc = '0;
    logic [csim_pkg::SUM_W-1:0] norm_a_acc = '0;
    logic [csim_pkg::SUM_W-1:0] norm_b_acc = '0;
    logic [csim_pkg::CNT_W-1:0] pairs_acc = '0;
    bit                         overlong = 1'b0;

    t_sim_result pending_sims[$];

    int  error_count = 0;
    int  pairs_sent = 0;
    int  vectors_sent = 0;
    int  results_checked = 0;
    int  status_seen[0:2] = '{0, 0, 0};
    int  stalled_requests = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    logic rx_hold = 1'b0;
    int  rx_wait = 0;

    cosine_similarity_stream uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_elem_a     (i_elem_a),
        .i_elem_b     (i_elem_b),
        .i_last_pair  (i_last_pair),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_similarity (o_similarity),
        .o_status     (o_status),
        .o_pair_count (o_pair_count)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // saturating accumulate
    function automatic logic [csim_pkg::SUM_W-1:0] add_sat(
        logic [csim_pkg::SUM_W-1:0] s,
        logic [csim_pkg::SUM_W-1:0] v
    );
        logic [csim_pkg::SUM_W:0] t;
        t = {1'b0, s} + {1'b0, v};
        return (t > {1'b0, SUM_SAT}) ? SUM_SAT : t[csim_pkg::SUM_W-1:0];
    endfunction

    // floor square root of a 128-bit value
    function automatic logic [63:0] floor_sqrt(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            c = r | (64'd1 << k);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= n) r = c;
        end
        return r;
    endfunction

    // fold one accepted pair into the sums; a last pair closes the vector
    task automatic fold_pair(logic [15:0] a, logic [15:0] b, logic last);
        t_sim_result  res;
        logic [127:0] norm_prod;
        logic [63:0]  root;
        logic [63:0]  quot;
        if (int'(pairs_acc) < PAIR_LIMIT) begin
            dot_acc    = add_sat(dot_acc, {16'd0, 32'(a) * 32'(b)});
            norm_a_acc = add_sat(norm_a_acc, {16'd0, 32'(a) * 32'(a)});
            norm_b_acc = add_sat(norm_b_acc, {16'd0, 32'(b) * 32'(b)});
            pairs_acc  = pairs_acc + 1'b1;
        end else begin
            overlong = 1'b1;
        end
        if (last) begin
            res.sim = '0;
            res.status = csim_pkg::ST_OK;
            if (norm_a_acc != 0 && norm_b_acc != 0) begin
                norm_prod = {80'd0, norm_a_acc} * {80'd0, norm_b_acc};
                root = floor_sqrt(norm_prod);
                if (root == 0) begin
                    res.sim = 16'hFFFF;
                end else begin
                    quot = {dot_acc, 16'd0} / root;
                    res.sim = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
                end
            end else begin
                res.status = csim_pkg::ST_ZERO;
            end
            if (overlong) res.status = csim_pkg::ST_LONG;
            res.count = (pairs_acc > csim_pkg::COUNT_MAX) ? csim_pkg::COUNT_MAX : pairs_acc;
            pending_sims.push_back(res);
            dot_acc = '0;
            norm_a_acc = '0;
            norm_b_acc = '0;
            pairs_acc = '0;
            overlong = 1'b0;
        end
    endtask

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
        error_count++;
    endtask

    // result side: random stall per result, long hold on request, compare on accept
    always @(posedge i_clk) begin : result_side
        t_sim_result want;
        logic        took;
        int          wait_n;
        took = i_rst_n && o_valid && !i_stall;
        wait_n = rx_wait;
        if (took) begin
            if (pending_sims.size() == 0) begin
                report_mismatch("unexpected result, similarity", o_similarity, 0);
            end else begin
                want = pending_sims.pop_front();
                if (o_similarity !== want.sim)
                    report_mismatch("similarity", o_similarity, want.sim);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_pair_count !== want.count)
                    report_mismatch("pair_count", o_pair_count, want.count);
                status_seen[int'(want.status)]++;
                results_checked++;
            end
            wait_n = rx_idle_on ? $urandom_range(0, 9) : 0;
        end else if (o_valid === 1'b1 && wait_n > 0) begin
            wait_n--;
        end
        i_stall <= rx_hold || (wait_n > 0);
        rx_wait <= wait_n;
    end

    // count cycles where a request is held back
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_stall === 1'b1) stalled_requests++;
    end

    // offer one request and wait until it is taken
    task automatic offer_pair(logic [15:0] a, logic [15:0] b, logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_elem_a <= a;
        i_elem_b <= b;
        i_last_pair <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        fold_pair(a, b, last);
        pairs_sent++;
        if (last) vectors_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_sims.size() != 0) @(posedge i_clk);
    endtask

    task automatic draw_pair(t_vec_style style, output logic [15:0] a, output logic [15:0] b);
        a = 16'($urandom_range(0, 65535));
        b = 16'($urandom_range(0, 65535));
        case (style)
            VEC_SMALL: begin
                a = 16'($urandom_range(0, 15));
                b = 16'($urandom_range(0, 15));
            end
            VEC_SPARSE: begin
                if ($urandom_range(0, 3) != 0) a = '0;
                if ($urandom_range(0, 3) != 0) b = '0;
            end
            VEC_HIGH: begin
                a = 16'($urandom_range(16'hF000, 16'hFFFF));
                b = 16'($urandom_range(16'hF000, 16'hFFFF));
            end
            VEC_ALIKE: begin
                b = a ^ 16'($urandom_range(0, 7));
            end
            VEC_ZERO_A: begin
                a = '0;
            end
            default: ;
        endcase
    endtask

    // extremes, zero norms, orthogonal and saturating cases
    task automatic test_extremes();
        offer_pair(16'hFFFF, 16'hFFFF, 1'b1);
        offer_pair(16'h0000, 16'h0000, 1'b1);
        offer_pair(16'h0000, 16'd1234, 1'b1);
        offer_pair(16'd4321, 16'h0000, 1'b1);
        offer_pair(16'd1, 16'd0, 1'b0);
        offer_pair(16'd0, 16'd1, 1'b1);
        offer_pair(16'hAAAA, 16'h5555, 1'b0);
        offer_pair(16'h5555, 16'hAAAA, 1'b1);
        offer_pair(16'd1, 16'd1, 1'b1);
        offer_pair(16'hFFFF, 16'd1, 1'b0);
        offer_pair(16'd1, 16'hFFFF, 1'b0);
        offer_pair(16'hFFFF, 16'hFFFF, 1'b1);
        offer_pair(16'd3, 16'd4, 1'b0);
        offer_pair(16'd4, 16'd3, 1'b1);
        offer_pair(16'h8000, 16'h0001, 1'b0);
        offer_pair(16'h0001, 16'h8000, 1'b0);
        offer_pair(16'h7FFF, 16'hFFFE, 1'b0);
        offer_pair(16'hFFFE, 16'h7FFF, 1'b0);
        offer_pair(16'h0000, 16'h0000, 1'b1);
    endtask

    // random vectors of mixed length and content, idling switched per vector
    task automatic test_random_vectors();
        t_vec_style   style;
        int           len;
        logic [15:0]  a;
        logic [15:0]  b;
        int           start_pairs;
        start_pairs = pairs_sent;
        while (pairs_sent - start_pairs < RANDOM_PAIRS) begin
            style = t_vec_style'($urandom_range(0, 5));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < len; k++) begin
                draw_pair(style, a, b);
                offer_pair(a, b, k == len - 1);
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while short vectors keep coming, so the input backs up
    task automatic test_result_hold();
        logic [15:0] a;
        logic [15:0] b;
        int          len;
        drain_results();
        tx_idle_on = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int v = 0; v < 12; v++) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
                draw_pair(VEC_FULL, a, b);
                offer_pair(a, b, k == len - 1);
            end
        end
        tx_idle_on = 1'b1;
        drain_results();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random_vectors();
        test_result_hold();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d pairs in %0d vectors, %0d results checked",
                 pairs_sent, vectors_sent, results_checked);
        $display("status ok/zero norm/too long: %0d/%0d/%0d, input held back %0d cycles",
                 status_seen[0], status_seen[1], status_seen[2], stalled_requests);
        if (error_count == 0)
            $display("tb_cosine_similarity_stream: done, clean");
        else
            $display("tb_cosine_similarity_stream: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("timeout at %0t with %0d results outstanding", $time, pending_sims.size());
        $display("tb_cosine_similarity_stream: done, errors");
        $finish;
    end

endmodule
